@@ rtl/tfa_pkg.sv @@
// Shared constants and types for the temporal frame averager.
`timescale 1ns / 1ps
package tfa_pkg;

  localparam int MAX_FRAME_BYTES = 262144;
  localparam int MAX_FRAMES      = 1024;

  localparam int POS_W   = $clog2(MAX_FRAME_BYTES);
  localparam int FB_W    = 19;
  localparam int NF_W    = 11;
  localparam int DONE_W  = 10;
  localparam int SUM_W   = 18;
  localparam int BYTE_W  = 8;
  localparam int STEP_W  = $clog2(SUM_W);

  localparam logic REG_FRAME_BYTES       = 1'b0;
  localparam logic REG_FRAMES_TO_AVERAGE = 1'b1;

  typedef struct packed {
    logic clear_step;
    logic accept;
    logic read;
    logic update;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic item_skip;
    logic item_final;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/tfa_ctrl.sv @@
// Sequencing state machine for the temporal frame averager.
`timescale 1ns / 1ps
module tfa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  tfa_pkg::status_t status,
  output tfa_pkg::cmd_t    cmd
);
  import tfa_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_OUT    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (!status.item_skip && status.item_final) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

@@ rtl/tfa_datapath.sv @@
// Sum store, frame bookkeeping, divider and output register.
`timescale 1ns / 1ps
module tfa_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  tfa_pkg::cmd_t                cmd,
  output tfa_pkg::status_t             status,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [tfa_pkg::FB_W-1:0]     cfg_data,
  input  logic [tfa_pkg::BYTE_W-1:0]   in_byte,
  input  logic                         in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [tfa_pkg::BYTE_W-1:0]   out_byte,
  output logic                         out_last
);
  import tfa_pkg::*;

  logic [FB_W-1:0]   frame_bytes;
  logic [NF_W-1:0]   frames_to_average;
  logic [SUM_W-1:0]  sum_mem [MAX_FRAME_BYTES];
  logic [SUM_W-1:0]  rd_data;
  logic [POS_W-1:0]  clr_cnt;
  logic [POS_W-1:0]  byte_position;
  logic [DONE_W-1:0] frames_done;
  logic              seen_key_frame;
  logic              skipping_frame;
  logic [POS_W-1:0]  addr;
  logic [BYTE_W-1:0] item_byte;
  logic              item_skip;
  logic              item_final;
  logic              item_last;
  logic [NF_W-1:0]   item_nf;
  logic [SUM_W-1:0]  div_q;
  logic [NF_W-1:0]   div_rem;
  logic [STEP_W-1:0] div_cnt;

  logic [FB_W-1:0]   fb_eff;
  logic [NF_W-1:0]   nf_eff;
  logic              eof;
  logic              fin;
  logic              skip_n;
  logic              seen_n;
  logic [SUM_W-1:0]  sum;
  logic              mem_we;
  logic [POS_W-1:0]  mem_wa;
  logic [SUM_W-1:0]  mem_wd;
  logic [NF_W:0]     trial;
  logic              qbit;

  always_comb begin
    fb_eff = frame_bytes;
    if (frame_bytes == '0) begin
      fb_eff = FB_W'(1);
    end else if (frame_bytes > FB_W'(MAX_FRAME_BYTES)) begin
      fb_eff = FB_W'(MAX_FRAME_BYTES);
    end
    nf_eff = frames_to_average;
    if (frames_to_average == '0) begin
      nf_eff = NF_W'(1);
    end else if (frames_to_average > NF_W'(MAX_FRAMES)) begin
      nf_eff = NF_W'(MAX_FRAMES);
    end
    eof = {1'b0, byte_position} >= (fb_eff - FB_W'(1));
    fin = {1'b0, frames_done} >= (nf_eff - NF_W'(1));
    skip_n = skipping_frame;
    seen_n = seen_key_frame;
    if (byte_position == '0) begin
      if (seen_key_frame) begin
        skip_n = 1'b0;
      end else if (in_key) begin
        seen_n = 1'b1;
        skip_n = 1'b0;
      end else begin
        skip_n = 1'b1;
      end
    end
    if (eof && !skip_n && fin) begin
      seen_n = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes       <= FB_W'(MAX_FRAME_BYTES);
      frames_to_average <= NF_W'(16);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_BYTES:       frame_bytes       <= cfg_data;
        REG_FRAMES_TO_AVERAGE: frames_to_average <= cfg_data[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      frames_done    <= '0;
      seen_key_frame <= 1'b0;
      skipping_frame <= 1'b0;
      clr_cnt        <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_cnt <= clr_cnt + POS_W'(1);
      end
      if (cmd.accept) begin
        seen_key_frame <= seen_n;
        skipping_frame <= skip_n;
        if (eof) begin
          byte_position <= '0;
          if (!skip_n) begin
            frames_done <= fin ? '0 : frames_done + DONE_W'(1);
          end
        end else begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr       <= byte_position;
      item_byte  <= in_byte;
      item_skip  <= skip_n;
      item_final <= fin;
      item_last  <= eof;
      item_nf    <= nf_eff;
    end
  end

  assign sum    = rd_data + SUM_W'(item_byte);
  assign mem_we = cmd.clear_step || (cmd.update && !item_skip);
  assign mem_wa = cmd.clear_step ? clr_cnt : addr;
  assign mem_wd = (cmd.clear_step || item_final) ? '0 : sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sum_mem[mem_wa] <= mem_wd;
    end
    if (cmd.read) begin
      rd_data <= sum_mem[addr];
    end
  end

  assign trial = {div_rem, div_q[SUM_W-1]};
  assign qbit  = trial >= {1'b0, item_nf};

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      div_q   <= sum;
      div_rem <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= qbit ? NF_W'(trial - {1'b0, item_nf}) : NF_W'(trial);
      div_q   <= {div_q[SUM_W-2:0], qbit};
      div_cnt <= div_cnt + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte <= (|div_q[SUM_W-1:BYTE_W]) ? {BYTE_W{1'b1}} : div_q[BYTE_W-1:0];
      out_last <= item_last;
    end
  end

  assign status.clear_last = clr_cnt == POS_W'(MAX_FRAME_BYTES - 1);
  assign status.item_skip  = item_skip;
  assign status.item_final = item_final;
  assign status.div_last   = div_cnt == STEP_W'(SUM_W - 1);
  assign status.out_free   = !out_valid || out_ready;

endmodule

@@ rtl/temporal_frame_averager_unit.sv @@
// Top level of the temporal frame averager.
`timescale 1ns / 1ps
// After reset the block clears its 262144-entry sum store, one entry per
// cycle, and takes no pixel transfer until the clear is done. Each accepted
// byte then goes through accept, a read of the sum store, and write back.
// A byte of the final frame of a run also goes through a radix-2 divider
// and a load of the output register. That load waits, and the input with
// it, while the previous result has not yet made its transfer.
// Configuration writes are taken in every cycle.
module temporal_frame_averager_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,  // pixel_byte
  input  logic                          s_tuser,  // key_frame
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // average_byte
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [tfa_pkg::FB_W-1:0]      cfg_data
);
  import tfa_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tfa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_tdata),
    .in_key    (s_tuser),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

@@ rtl/tfa_checker.sv @@
// Port-level assertions for the temporal frame averager, bound to the top level.
`timescale 1ns / 1ps
module tfa_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("Ports not quiet after reset.");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("Input taken in two consecutive cycles.");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("Result dropped before its transfer.");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("Result changed while stalled.");

endmodule

bind temporal_frame_averager_unit tfa_checker u_tfa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ test/temporal_frame_averager_unit_test.sv @@
// Self-checking testbench for the temporal frame averager top level.
`timescale 1ns / 1ps
module temporal_frame_averager_unit_test;
  import tfa_pkg::*;

  typedef struct packed {
    logic [7:0] average;
    logic       last;
  } average_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [FB_W-1:0] cfg_data = '0;

  temporal_frame_averager_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Model state of the averager.
  int unsigned frame_len_reg;
  int unsigned frame_count_reg;
  int unsigned position_sums [int unsigned];
  int unsigned byte_pos;
  int unsigned frames_summed;
  bit key_seen;
  bit skip_frame;

  average_t averages_due[$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 1'b0;
  int hold_off = 0;

  task automatic predict_average(input logic [7:0] pixel, input logic key);
    int unsigned flen, fcount, pos, total, quot;
    bit frame_end, last_frame;
    average_t res;
    flen = frame_len_reg == 0 ? 1 : (frame_len_reg > MAX_FRAME_BYTES ? MAX_FRAME_BYTES
                                                                       : frame_len_reg);
    fcount = frame_count_reg == 0 ? 1 : (frame_count_reg > MAX_FRAMES ? MAX_FRAMES
                                                                        : frame_count_reg);
    pos = byte_pos >= MAX_FRAME_BYTES ? MAX_FRAME_BYTES - 1 : byte_pos;
    frame_end = pos >= flen - 1;
    if (pos == 0) begin
      if (key_seen) begin
        skip_frame = 1'b0;
      end else if (key) begin
        key_seen = 1'b1;
        skip_frame = 1'b0;
      end else begin
        skip_frame = 1'b1;
      end
    end
    last_frame = frames_summed >= fcount - 1;
    if (!skip_frame) begin
      total = (position_sums.exists(pos) ? position_sums[pos] : 0) + pixel;
      if (last_frame) begin
        quot = total / fcount;
        res.average = quot > 255 ? 8'd255 : quot[7:0];
        res.last = frame_end;
        averages_due.push_back(res);
        position_sums[pos] = 0;
      end else begin
        position_sums[pos] = total;
      end
    end
    if (frame_end) begin
      byte_pos = 0;
      if (!skip_frame) begin
        if (last_frame) begin
          frames_summed = 0;
          key_seen = 1'b0;
        end else begin
          frames_summed++;
        end
      end
    end else begin
      byte_pos = pos + 1;
    end
  endtask

  task automatic send_byte(input logic [7:0] pixel, input logic key);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pixel;
    s_tuser <= key;
    do @(posedge clk); while (!s_tready);
    predict_average(pixel, key);
    items_sent++;
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned len, input logic key, input bit noisy_key);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)),
                (i == 0) ? key : (noisy_key ? 1'($urandom_range(0, 1)) : key));
    end
  endtask

  // Registers are only written once every expected average has come out.
  task automatic write_reg(input logic index, input logic [FB_W-1:0] value);
    wait (averages_due.size() == 0);
    repeat (30) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_FRAME_BYTES) frame_len_reg = value;
    else frame_count_reg = value[NF_W-1:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_extremes;
    write_reg(REG_FRAME_BYTES, 19'd1);
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd0);
    send_byte(8'd0, 1'b1);
    send_byte(8'd255, 1'b1);
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd2);
    send_byte(8'd255, 1'b1);
    send_byte(8'd254, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd1, 1'b0);
  endtask

  task automatic test_skip_until_key;
    write_reg(REG_FRAME_BYTES, 19'd3);
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd2);
    send_byte(8'd9, 1'b0);
    send_byte(8'd9, 1'b1);
    send_byte(8'd9, 1'b1);
    send_frame(3, 1'b1, 1'b0);
    send_frame(3, 1'b0, 1'b1);
  endtask

  task automatic test_length_change_mid_frame;
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd1);
    write_reg(REG_FRAME_BYTES, 19'h7FFFF);
    send_frame(5, 1'b1, 1'b0);
    write_reg(REG_FRAME_BYTES, 19'd0);
    send_byte(8'hA5, 1'b0);
    write_reg(REG_FRAME_BYTES, 19'd2);
    send_frame(2, 1'b1, 1'b0);
  endtask

  // A run started with an oversized count and closed early overflows the quotient.
  task automatic test_count_change_mid_run;
    write_reg(REG_FRAMES_TO_AVERAGE, 19'h7FF);
    send_byte(8'd255, 1'b1);
    send_byte(8'd255, 1'b0);
    send_byte(8'd200, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(8'd200, 1'b0);
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd2);
    send_byte(8'd255, 1'b0);
  endtask

  task automatic test_output_backpressure;
    write_reg(REG_FRAME_BYTES, 19'd4);
    write_reg(REG_FRAMES_TO_AVERAGE, 19'd1);
    hold_off = 300;
    repeat (6) send_frame(4, 1'b1, 1'b0);
  endtask

  task automatic test_random_runs(input int target);
    int unsigned len;
    int unsigned count;
    while (items_sent < target) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      write_reg(REG_FRAME_BYTES, FB_W'(len));
      write_reg(REG_FRAMES_TO_AVERAGE, FB_W'(count));
      if (len == 0) len = 1;
      if (count == 0) count = 1;
      repeat ($urandom_range(1, 3) * (count + 1)) begin
        send_frame(len, $urandom_range(0, 5) != 0, $urandom_range(0, 3) == 0);
      end
    end
  endtask

  initial begin
    frame_len_reg = MAX_FRAME_BYTES;
    frame_count_reg = 16;
    byte_pos = 0;
    frames_summed = 0;
    key_seen = 1'b0;
    skip_frame = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_skip_until_key();
    test_length_change_mid_frame();
    test_count_change_mid_run();
    test_output_backpressure();
    test_random_runs(520);
    quiet = 1'b1;
    test_random_runs(635);
    wait (averages_due.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  always begin
    @(negedge clk);
    if (hold_off > 0) begin
      m_tready <= 1'b0;
      hold_off--;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 4) - 1) @(negedge clk);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    average_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (averages_due.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual data %0d last %0b",
                 $time, m_tdata, m_tlast);
        errors++;
      end else begin
        want = averages_due.pop_front();
        if (m_tdata !== want.average) begin
          $display("%0t: average mismatch, expected %0d, actual %0d",
                   $time, want.average, m_tdata);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last mismatch, expected %0b, actual %0b",
                   $time, want.last, m_tlast);
          errors++;
        end
      end
    end
  end

endmodule
